// File: hw/rtl/mccc_pkg.sv
`timescale 1ns / 1ps

package mccc_pkg;

   localparam int CountWidth = 11;
   localparam int NumSlots   = 5;
   localparam int QualWidth  = 7;
   localparam int BaseWidth  = 3;

   localparam logic [BaseWidth-1:0] BaseA = 3'd0;
   localparam logic [BaseWidth-1:0] BaseC = 3'd1;
   localparam logic [BaseWidth-1:0] BaseG = 3'd2;
   localparam logic [BaseWidth-1:0] BaseT = 3'd3;
   localparam logic [BaseWidth-1:0] BaseN = 3'd4;

   // counter slots share the base codes; the gap counter sits in the N position
   localparam logic [BaseWidth-1:0] SlotGap = 3'd4;

   localparam logic [QualWidth-1:0] QualMax = 7'd93;

   typedef logic [NumSlots-1:0][CountWidth-1:0] counts_type;

   typedef struct packed {
      logic                  start;
      logic [CountWidth-1:0] count;
      logic [CountWidth-1:0] rows;
   } qual_req_type;

endpackage

// File: hw/rtl/mccc_qual_unit.sv
`timescale 1ns / 1ps

// round(93 * (2c - h) / h) for h/2 < c < h, as (2 * 93 * (2c - h) + h) / (2h)
module mccc_qual_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  mccc_pkg::qual_req_type              req,
   output logic                                done,
   output logic [mccc_pkg::QualWidth-1:0]      quality
);
   import mccc_pkg::*;

   localparam int NumWidth = CountWidth + QualWidth;   // 93 * diff
   localparam int DvdWidth = NumWidth + 1;             // 2 * num + h
   localparam int DsrWidth = CountWidth + QualWidth;   // (2h) aligned to the top quotient bit
   localparam int StepWidth = $clog2(QualWidth);

   typedef enum logic [2:0] {
      Q_IDLE = 3'b001,
      Q_MUL  = 3'b010,
      Q_DIV  = 3'b100
   } qstate_type;

   qstate_type                state_ff, state_in;
   logic [CountWidth-1:0]     diff_ff, diff_in;
   logic [CountWidth-1:0]     rows_ff, rows_in;
   logic [DvdWidth-1:0]       rem_ff, rem_in;
   logic [DsrWidth-1:0]       dsor_ff, dsor_in;
   logic [QualWidth-1:0]      quot_ff, quot_in;
   logic [StepWidth-1:0]      step_ff, step_in;
   logic                      done_ff, done_in;
   logic [NumWidth-1:0]       num;
   logic [CountWidth:0]       diff_wide;
   logic                      fits;

   always_comb begin
      diff_wide = {req.count, 1'b0} - {1'b0, req.rows};
      num       = NumWidth'(diff_ff) * NumWidth'(QualMax);
      fits      = rem_ff >= DvdWidth'(dsor_ff);
      state_in  = state_ff;
      diff_in   = diff_ff;
      rows_in   = rows_ff;
      rem_in    = rem_ff;
      dsor_in   = dsor_ff;
      quot_in   = quot_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      case (state_ff)
         Q_IDLE: begin
            if (req.start) begin
               diff_in  = diff_wide[CountWidth-1:0];
               rows_in  = req.rows;
               state_in = Q_MUL;
            end
         end
         Q_MUL: begin
            rem_in   = {num, 1'b0} + DvdWidth'(rows_ff);
            dsor_in  = {rows_ff, QualWidth'(0)};
            quot_in  = '0;
            step_in  = '0;
            state_in = Q_DIV;
         end
         Q_DIV: begin
            if (fits) begin
               rem_in = rem_ff - DvdWidth'(dsor_ff);
            end
            quot_in = {quot_ff[QualWidth-2:0], fits};
            dsor_in = dsor_ff >> 1;
            step_in = step_ff + StepWidth'(1);
            if (step_ff == StepWidth'(QualWidth - 1)) begin
               done_in  = 1'b1;
               state_in = Q_IDLE;
            end
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      diff_ff <= diff_in;
      rows_ff <= rows_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign done    = done_ff;
   assign quality = quot_ff;

endmodule

// File: hw/rtl/msa_column_consensus_caller.sv
`timescale 1ns / 1ps

// Column consensus caller.
// Command channel: an item is taken on a rising edge with start high and busy low.
//   req_action 0 adds req_symbol to column req_column (case folded; A, C, G, T and
//   '-' are counted, every add to column zero also counts a row). req_action 1
//   drains the column: it is read and cleared, and row count is cleared after it
//   when req_final_column is set.
// Result channel: rsp_valid is high for one cycle with the drained column, its
//   base (0 A, 1 C, 2 G, 3 T, 4 N), its quality and the echoed final flag. No
//   result is given at row count zero or for a mostly-gap or out-of-range column.
// Timing: one counter memory port pair sets the pace. An add keeps busy high
//   through S_ACCESS after the transfer. A drain of an out-of-range column runs
//   S_ACCESS only, any other drain with no result S_ACCESS and S_EVAL, a drain
//   whose quality is 0 or 93 S_ACCESS, S_EVAL and S_EMIT, and one that needs the
//   serial quality divider (multiply, 7 quotient bit steps, hand-off) also S_QUAL
//   before S_EMIT; the result strobe is in S_EMIT.
// Reset: synchronous. After it the counter memory is swept to zero, one entry per
//   cycle over all min(MAX_COLUMNS, 4096) entries, with busy high.
// The receiver cannot stall; each result is presented once.
module msa_column_consensus_caller #(
   parameter int MAX_COLUMNS = 4096,
   parameter int MAX_ROWS    = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [11:0]                        req_column,
   input  logic [7:0]                         req_symbol,
   input  logic                               req_final_column,
   output logic                               rsp_valid,
   output logic [11:0]                        rsp_result_column,
   output logic [mccc_pkg::BaseWidth-1:0]     rsp_base,
   output logic [mccc_pkg::QualWidth-1:0]     rsp_quality,
   output logic                               rsp_last_column
);
   import mccc_pkg::*;

   localparam int MemDepth  = (MAX_COLUMNS < 4096) ? MAX_COLUMNS : 4096;
   localparam int AddrWidth = (MemDepth > 1) ? $clog2(MemDepth) : 1;
   localparam logic [CountWidth-1:0] CntLimit =
      CountWidth'((MAX_ROWS < 2047) ? MAX_ROWS : 2047);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_ACCESS = 6'b000100,
      S_EVAL   = 6'b001000,
      S_QUAL   = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      return (v >= CntLimit) ? CntLimit : v + CountWidth'(1);
   endfunction

   counts_type                mem [MemDepth];
   counts_type                rd_data_ff;
   logic                      mem_we;
   logic [AddrWidth-1:0]      mem_waddr;
   counts_type                mem_wdata;
   logic                      mem_re;

   state_type                 state_ff, state_in;
   logic [AddrWidth-1:0]      clr_addr_ff, clr_addr_in;
   logic [CountWidth-1:0]     row_count_ff, row_count_in;
   logic [CountWidth-1:0]     hrow_ff, hrow_in;
   logic                      action_ff, action_in;
   logic [11:0]               col_ff, col_in;
   logic                      in_range_ff, in_range_in;
   logic [BaseWidth-1:0]      slot_ff, slot_in;
   logic                      slot_ok_ff, slot_ok_in;
   logic                      fin_ff, fin_in;
   logic [BaseWidth-1:0]      base_ff, base_in;
   logic [QualWidth-1:0]      qual_ff, qual_in;

   logic                      accept;
   logic                      req_in_range;
   logic [BaseWidth-1:0]      dec_slot;
   logic                      dec_ok;
   counts_type                upd;
   logic [CountWidth-1:0]     best;
   logic [BaseWidth-1:0]      lead_base;
   logic                      produce;
   logic                      over_half;
   qual_req_type              qreq;
   logic                      qdone;
   logic [QualWidth-1:0]      qvalue;

   mccc_qual_unit u_qual (
      .clock   (clock),
      .reset   (reset),
      .req     (qreq),
      .done    (qdone),
      .quality (qvalue)
   );

   assign busy         = (state_ff != S_IDLE);
   assign accept       = start && (state_ff == S_IDLE);
   assign req_in_range = 32'(req_column) < MAX_COLUMNS;

   // symbol decode with lower case folded
   always_comb begin
      dec_ok   = 1'b1;
      dec_slot = BaseA;
      case (req_symbol)
         8'h41, 8'h61: dec_slot = BaseA;
         8'h43, 8'h63: dec_slot = BaseC;
         8'h47, 8'h67: dec_slot = BaseG;
         8'h54, 8'h74: dec_slot = BaseT;
         8'h2D:        dec_slot = SlotGap;
         default:      dec_ok   = 1'b0;
      endcase
   end

   // winner: highest count, ties go to the lower base code; N if all counts are zero
   always_comb begin
      best      = '0;
      lead_base = BaseN;
      for (int b = 0; b < 4; b++) begin
         if (rd_data_ff[b] > best) begin
            best      = rd_data_ff[b];
            lead_base = BaseWidth'(b);
         end
      end
      over_half = {best, 1'b0} > {1'b0, hrow_ff};
      produce   = (hrow_ff != '0) && !({rd_data_ff[SlotGap], 1'b0} > {1'b0, hrow_ff});
   end

   always_comb begin
      upd = rd_data_ff;
      if (slot_ok_ff) begin
         upd[slot_ff] = sat_inc(rd_data_ff[slot_ff]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      row_count_in = row_count_ff;
      hrow_in      = hrow_ff;
      action_in    = action_ff;
      col_in       = col_ff;
      in_range_in  = in_range_ff;
      slot_in      = slot_ff;
      slot_ok_in   = slot_ok_ff;
      fin_in       = fin_ff;
      base_in      = base_ff;
      qual_in      = qual_ff;
      mem_we       = 1'b0;
      mem_waddr    = col_ff[AddrWidth-1:0];
      mem_wdata    = '0;
      mem_re       = 1'b0;
      qreq         = '0;
      qreq.count   = best;
      qreq.rows    = hrow_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AddrWidth'(1);
            if (clr_addr_ff == AddrWidth'(MemDepth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               action_in   = req_action;
               col_in      = req_column;
               in_range_in = req_in_range;
               slot_in     = dec_slot;
               slot_ok_in  = dec_ok;
               fin_in      = req_final_column;
               mem_re      = req_in_range;
               state_in    = S_ACCESS;
            end
         end
         S_ACCESS: begin
            hrow_in  = row_count_ff;
            state_in = S_IDLE;
            if (!action_ff) begin
               if (in_range_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = upd;
                  if (col_ff == '0) begin
                     row_count_in = sat_inc(row_count_ff);
                  end
               end
            end else begin
               if (in_range_ff) begin
                  mem_we   = 1'b1;
                  state_in = S_EVAL;
               end
               if (fin_ff) begin
                  row_count_in = '0;
               end
            end
         end
         S_EVAL: begin
            base_in = over_half ? lead_base : BaseN;
            if (!produce) begin
               state_in = S_IDLE;
            end else if (!over_half) begin
               qual_in  = '0;
               state_in = S_EMIT;
            end else if (best >= hrow_ff) begin
               qual_in  = QualMax;
               state_in = S_EMIT;
            end else begin
               qreq.start = 1'b1;
               state_in   = S_QUAL;
            end
         end
         S_QUAL: begin
            if (qdone) begin
               qual_in  = qvalue;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[req_column[AddrWidth-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         row_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         row_count_ff <= row_count_in;
      end
      hrow_ff     <= hrow_in;
      action_ff   <= action_in;
      col_ff      <= col_in;
      in_range_ff <= in_range_in;
      slot_ff     <= slot_in;
      slot_ok_ff  <= slot_ok_in;
      fin_ff      <= fin_in;
      base_ff     <= base_in;
      qual_ff     <= qual_in;
   end

   assign rsp_valid         = (state_ff == S_EMIT);
   assign rsp_result_column = col_ff;
   assign rsp_base          = base_ff;
   assign rsp_quality       = qual_ff;
   assign rsp_last_column   = fin_ff;

endmodule
